### src/isl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isl_pkg - shared types and constants of the indexed shift list
// List depth, field widths, action and status codes, cell opcodes and the
// result record that travels to the output queue.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int DEPTH       = 32;
    localparam int MAX_RESULTS = 32;
    localparam int WORD_W      = 32;
    localparam int ACT_W       = 3;
    localparam int POS_W       = 5;
    localparam int CNT_OUT_W   = 6;
    localparam int ST_W        = 2;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    // common width for comparing counts, positions and the result limit
    localparam int CMP_W       = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_EDIT   = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_LIST   = 3'd4,
        ACT_CLEAR  = 3'd5
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LOWER,
        CELL_UPPER
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    typedef struct packed {
        status_t                status;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]       position;
        logic [CNT_OUT_W-1:0]   count;
        logic                   last;
    } res_t;

endpackage
`default_nettype wire

### src/isl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isl_cell - one slot of the shift list
// Holds one word; each cycle it keeps it, loads the new word, or takes the
// word of its lower or upper neighbour.
// ----------------------------------------------------------------------------
module isl_cell (
    input  wire logic                          clk,
    input  wire isl_pkg::cell_op_t             op,
    input  wire logic signed [isl_pkg::WORD_W-1:0] load_word,
    input  wire logic signed [isl_pkg::WORD_W-1:0] lower_word,
    input  wire logic signed [isl_pkg::WORD_W-1:0] upper_word,
    output logic signed [isl_pkg::WORD_W-1:0]      word
);
    import isl_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb
    begin
        case (op)
            CELL_HOLD:  word_next = word_reg;
            CELL_LOAD:  word_next = load_word;
            CELL_LOWER: word_next = lower_word;
            CELL_UPPER: word_next = upper_word;
            default:    word_next = word_reg;
        endcase
    end

    // contents are undefined until written, so no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule
`default_nettype wire

### src/isl_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isl_out_fifo - two-entry result queue
// Output register plus skid slot, so the list can go on while a result waits.
// ----------------------------------------------------------------------------
module isl_out_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire isl_pkg::res_t push_data,
    output logic               full,
    output logic               out_valid,
    input  wire logic          out_stall,
    output isl_pkg::res_t      head
);
    import isl_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    res_t       head_reg;
    res_t       head_next;
    res_t       tail_reg;
    res_t       tail_next;
    logic       pop;
    logic [1:0] cnt_after;

    always_comb
    begin
        pop       = (cnt_reg != 2'd0) && !out_stall;
        cnt_after = cnt_reg - {1'b0, pop};
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop)
        begin
            head_next = tail_reg;
        end
        if (push)
        begin
            if (cnt_after == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
        end
        cnt_next = cnt_after + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign head      = head_reg;

endmodule
`default_nettype wire

### src/indexed_shift_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_shift_list - ordered list of signed words with insert/delete shift
// A row of cells holds the list; insert and delete move the cells above the
// position by one slot at once. Listing reads one entry a cycle unless q_full.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_stall    action, value, position
//  output    out_valid / out_stall  status, value_res, position_res, count, last
//
//  append, insert, edit, delete and clear each give one item.
//  list all gives one item per entry (up to 32), one item each cycle while the
//  output queue is not full; an empty list gives one item.
//  a two-entry output queue takes results; in_stall is high during a listing
//  and while the queue is full.
//  after reset the list is empty; entry contents are undefined until written.
// ----------------------------------------------------------------------------
module indexed_shift_list (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [isl_pkg::ACT_W-1:0]       action,
    input  wire logic signed [isl_pkg::WORD_W-1:0] value,
    input  wire logic [isl_pkg::POS_W-1:0]       position,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [isl_pkg::ST_W-1:0]             status,
    output logic signed [isl_pkg::WORD_W-1:0]    value_res,
    output logic [isl_pkg::POS_W-1:0]            position_res,
    output logic [isl_pkg::CNT_OUT_W-1:0]        count,
    output logic                                 last
);
    import isl_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic [IDX_W-1:0]         list_idx_reg;
    logic [IDX_W-1:0]         list_idx_next;
    logic [IDX_W-1:0]         list_end_reg;
    logic [IDX_W-1:0]         list_end_next;

    cell_op_t                 ops [DEPTH];
    logic signed [WORD_W-1:0] words [DEPTH];
    logic [IDX_W-1:0]         rd_addr;
    logic signed [WORD_W-1:0] rd_word;

    logic                     accept;
    logic                     push;
    logic                     q_full;
    res_t                     res;
    res_t                     head;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         lim;
    logic                     is_full;

    assign cnt_ext  = CMP_W'(fill_reg);
    assign pos_ext  = CMP_W'(position);
    assign is_full  = (cnt_ext >= CMP_W'(DEPTH));
    assign in_stall = (state_reg == S_LIST) || q_full;
    assign accept   = in_valid && !in_stall;
    assign lim      = (cnt_ext > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS) : cnt_ext;

    // single read port: listing counter or requested position
    assign rd_addr = (state_reg == S_LIST) ? list_idx_reg : pos_ext[IDX_W-1:0];
    assign rd_word = words[rd_addr];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [WORD_W-1:0] lower_w;
            logic signed [WORD_W-1:0] upper_w;
            if (g == 0)
            begin : g_first
                assign lower_w = '0;
            end
            else
            begin : g_mid_lo
                assign lower_w = words[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_top
                assign upper_w = '0;
            end
            else
            begin : g_mid_hi
                assign upper_w = words[g+1];
            end
            isl_cell u_cell (
                .clk        (clk),
                .op         (ops[g]),
                .load_word  (value),
                .lower_word (lower_w),
                .upper_word (upper_w),
                .word       (words[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        list_idx_next = list_idx_reg;
        list_end_next = list_end_reg;
        push          = 1'b0;
        res.status    = ST_OK;
        res.value     = '0;
        res.position  = '0;
        res.last      = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            ops[i] = CELL_HOLD;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_APPEND:
                        begin
                            push = 1'b1;
                            if (is_full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CMP_W'(i) == cnt_ext)
                                    begin
                                        ops[i] = CELL_LOAD;
                                    end
                                end
                                fill_next    = fill_reg + CNT_W'(1);
                                res.value    = value;
                                res.position = POS_W'(cnt_ext);
                            end
                        end
                        ACT_INSERT:
                        begin
                            push         = 1'b1;
                            res.position = position;
                            if (is_full)
                            begin
                                res.status = ST_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CMP_W'(i) == pos_ext)
                                    begin
                                        ops[i] = CELL_LOAD;
                                    end
                                    else if (CMP_W'(i) > pos_ext && CMP_W'(i) <= cnt_ext)
                                    begin
                                        ops[i] = CELL_LOWER;
                                    end
                                end
                                fill_next = fill_reg + CNT_W'(1);
                                res.value = value;
                            end
                        end
                        ACT_EDIT:
                        begin
                            push         = 1'b1;
                            res.position = position;
                            if (pos_ext >= cnt_ext)
                            begin
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CMP_W'(i) == pos_ext)
                                    begin
                                        ops[i] = CELL_LOAD;
                                    end
                                end
                                res.value = rd_word;
                            end
                        end
                        ACT_DELETE:
                        begin
                            push         = 1'b1;
                            res.position = position;
                            if (pos_ext >= cnt_ext)
                            begin
                                res.status = ST_RANGE;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CMP_W'(i) >= pos_ext
                                        && CMP_W'(i) + CMP_W'(1) < cnt_ext)
                                    begin
                                        ops[i] = CELL_UPPER;
                                    end
                                end
                                fill_next = fill_reg - CNT_W'(1);
                                res.value = rd_word;
                            end
                        end
                        ACT_LIST:
                        begin
                            if (cnt_ext == '0)
                            begin
                                push       = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next    = S_LIST;
                                list_idx_next = '0;
                                list_end_next = IDX_W'(lim - CMP_W'(1));
                            end
                        end
                        ACT_CLEAR:
                        begin
                            push      = 1'b1;
                            fill_next = '0;
                        end
                        default:
                        begin
                            // unused codes give no result
                            push = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (!q_full)
                begin
                    push         = 1'b1;
                    res.value    = rd_word;
                    res.position = POS_W'(CMP_W'(list_idx_reg));
                    res.last     = (list_idx_reg == list_end_reg);
                    if (list_idx_reg == list_end_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        list_idx_next = list_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.count = CNT_OUT_W'(CMP_W'(fill_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            list_idx_reg <= '0;
            list_end_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            list_idx_reg <= list_idx_next;
            list_end_reg <= list_end_next;
        end
    end

    isl_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign status       = head.status;
    assign value_res    = head.value;
    assign position_res = head.position;
    assign count        = head.count;
    assign last         = head.last;

endmodule
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking testbench of the indexed shift list
// A queue of pending operations feeds a clocked driver with random gaps; a
// clocked monitor stalls the output at random and checks every result against
// a shadow list kept in the testbench. A short directed opening covers empty,
// edge and error cases, then random well-formed runs, fill-to-full bursts,
// broken positions and raw noise follow. One long output hold-off backs the
// list up into its input.
// ----------------------------------------------------------------------------
module tb;
    import isl_pkg::*;

    localparam int RANDOM_OPS    = 88;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 2 * MAX_RESULTS + 8;
    localparam int HOLD_AT_ITEM  = 45;
    localparam int HOLD_CYCLES   = 120;
    localparam int QUIET_FROM    = 70;
    localparam int QUIET_TO      = 90;
    localparam int MAX_REPORTS   = 10;

    // action codes the list does not decode
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]         act;
        logic signed [WORD_W-1:0] val;
        logic [POS_W-1:0]         pos;
    } list_op_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic [ACT_W-1:0]         action    = '0;
    logic signed [WORD_W-1:0] value     = '0;
    logic [POS_W-1:0]         position  = '0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic [ST_W-1:0]          status;
    logic signed [WORD_W-1:0] value_res;
    logic [POS_W-1:0]         position_res;
    logic [CNT_OUT_W-1:0]     count;
    logic                     last;

    indexed_shift_list u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .value        (value),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .value_res    (value_res),
        .position_res (position_res),
        .count        (count),
        .last         (last)
    );

    list_op_t pending_ops[$];
    list_op_t offered_op;
    res_t     predicted_results[$];
    res_t     oldest_result;

    logic signed [WORD_W-1:0] list_words [DEPTH];
    int list_fill;

    int gen_fill;
    int ops_queued;
    int items_accepted;
    int driver_gap;
    int stall_left;
    int hold_left;
    bit hold_done;
    int cycle_count = 0;
    int fail_count;
    int results_checked;
    int listings_seen;
    int full_rejects;
    logic quiet;

    assign quiet = (items_accepted >= QUIET_FROM) && (items_accepted < QUIET_TO);

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // shadow list
    // ------------------------------------------------------------------
    function automatic void add_predicted(status_t st, logic signed [WORD_W-1:0] word,
                                          int slot, logic fin);
        res_t r;
        r.status   = st;
        r.value    = word;
        r.position = POS_W'(slot);
        r.count    = CNT_OUT_W'(list_fill);
        r.last     = fin;
        predicted_results.push_back(r);
    endfunction

    task automatic apply_list_op(input list_op_t op);
        int slot;
        int i;
        int span;
        logic signed [WORD_W-1:0] prior;
        slot = int'(op.pos);
        case (op.act)
            ACT_APPEND:
            begin
                if (list_fill >= DEPTH)
                begin
                    full_rejects++;
                    add_predicted(ST_FULL, '0, 0, 1'b1);
                end
                else
                begin
                    list_words[list_fill] = op.val;
                    list_fill++;
                    add_predicted(ST_OK, op.val, list_fill - 1, 1'b1);
                end
            end
            ACT_INSERT:
            begin
                if (list_fill >= DEPTH)
                begin
                    full_rejects++;
                    add_predicted(ST_FULL, '0, slot, 1'b1);
                end
                else if (slot > list_fill)
                    add_predicted(ST_RANGE, '0, slot, 1'b1);
                else
                begin
                    for (i = list_fill; i > slot; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[slot] = op.val;
                    list_fill++;
                    add_predicted(ST_OK, op.val, slot, 1'b1);
                end
            end
            ACT_EDIT:
            begin
                if (slot >= list_fill)
                    add_predicted(ST_RANGE, '0, slot, 1'b1);
                else
                begin
                    prior = list_words[slot];
                    list_words[slot] = op.val;
                    add_predicted(ST_OK, prior, slot, 1'b1);
                end
            end
            ACT_DELETE:
            begin
                if (slot >= list_fill)
                    add_predicted(ST_RANGE, '0, slot, 1'b1);
                else
                begin
                    prior = list_words[slot];
                    for (i = slot; i + 1 < list_fill; i++)
                        list_words[i] = list_words[i + 1];
                    list_words[list_fill - 1] = '0;
                    list_fill--;
                    add_predicted(ST_OK, prior, slot, 1'b1);
                end
            end
            ACT_LIST:
            begin
                listings_seen++;
                if (list_fill == 0)
                    add_predicted(ST_EMPTY, '0, 0, 1'b1);
                else
                begin
                    span = (list_fill > MAX_RESULTS) ? MAX_RESULTS : list_fill;
                    for (i = 0; i < span; i++)
                        add_predicted(ST_OK, list_words[i], i, i + 1 == span);
                end
            end
            ACT_CLEAR:
            begin
                for (i = 0; i < DEPTH; i++)
                    list_words[i] = '0;
                list_fill = 0;
                add_predicted(ST_OK, '0, 0, 1'b1);
            end
            default:
            begin
                // spare codes give nothing
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic void queue_op(logic [ACT_W-1:0] act, logic signed [WORD_W-1:0] word,
                                     int slot);
        list_op_t op;
        op.act = act;
        op.val = word;
        op.pos = POS_W'(slot);
        pending_ops.push_back(op);
        case (act)
            ACT_APPEND: if (gen_fill < DEPTH) gen_fill++;
            ACT_INSERT: if (gen_fill < DEPTH && int'(op.pos) <= gen_fill) gen_fill++;
            ACT_DELETE: if (int'(op.pos) < gen_fill) gen_fill--;
            ACT_CLEAR:  gen_fill = 0;
            default:    ;
        endcase
        if (act <= ACT_CLEAR)
            ops_queued++;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int top_slot();
        return (gen_fill > DEPTH - 1) ? DEPTH - 1 : gen_fill;
    endfunction

    task automatic queue_fill_burst();
        while (gen_fill < DEPTH)
        begin
            if ($urandom_range(0, 1))
                queue_op(ACT_APPEND, rand_word(), $urandom_range(0, 31));
            else
                queue_op(ACT_INSERT, rand_word(), $urandom_range(0, gen_fill));
        end
        // rejected while full, then work at the top slot
        queue_op(ACT_APPEND, rand_word(), $urandom_range(0, 31));
        queue_op(ACT_INSERT, rand_word(), $urandom_range(0, 31));
        queue_op(ACT_LIST, rand_word(), $urandom_range(0, 31));
        queue_op(ACT_EDIT, rand_word(), DEPTH - 1);
        queue_op(ACT_DELETE, rand_word(), DEPTH - 1);
        queue_op(ACT_INSERT, rand_word(), DEPTH - 1);
        queue_op(ACT_LIST, rand_word(), $urandom_range(0, 31));
    endtask

    task automatic queue_valid_op();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 6 || (pick >= 10 && pick < 17 && gen_fill == 0))
            queue_op(ACT_APPEND, rand_word(), $urandom_range(0, 31));
        else if (pick < 10)
            queue_op(ACT_INSERT, rand_word(), $urandom_range(0, top_slot()));
        else if (pick < 14)
            queue_op(ACT_EDIT, rand_word(), $urandom_range(0, gen_fill - 1));
        else if (pick < 17)
            queue_op(ACT_DELETE, rand_word(), $urandom_range(0, gen_fill - 1));
        else if (pick < 19)
            queue_op(ACT_LIST, rand_word(), $urandom_range(0, 31));
        else
            queue_op(ACT_CLEAR, rand_word(), $urandom_range(0, 31));
    endtask

    task automatic queue_broken_op();
        case ($urandom_range(0, 2))
            0:
                if (gen_fill < DEPTH - 1)
                    queue_op(ACT_INSERT, rand_word(), $urandom_range(gen_fill + 1, 31));
                else
                    queue_op(ACT_INSERT, rand_word(), $urandom_range(0, 31));
            1:
                queue_op(ACT_EDIT, rand_word(), $urandom_range(top_slot(), 31));
            default:
                queue_op(ACT_DELETE, rand_word(), $urandom_range(top_slot(), 31));
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            items_accepted <= 0;
            driver_gap      = 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                apply_list_op(offered_op);
                items_accepted <= items_accepted + 1;
            end
            if (driver_gap > 0)
            begin
                driver_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                offered_op = pending_ops.pop_front();
                action     <= offered_op.act;
                value      <= offered_op.val;
                position   <= offered_op.pos;
                in_valid   <= 1'b1;
                driver_gap  = quiet ? 0 : $urandom_range(0, 4);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long output hold-off, once, while the sender keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_accepted >= HOLD_AT_ITEM)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: status %0d value %h pos %0d",
                                 status, value_res, position_res,
                                 " count %0d last %0d", count, last);
                end
                else
                begin
                    oldest_result = predicted_results.pop_front();
                    results_checked++;
                    if (status !== oldest_result.status || value_res !== oldest_result.value ||
                        position_res !== oldest_result.position ||
                        count !== oldest_result.count || last !== oldest_result.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch at result %0d: expected st %0d val %h",
                                     results_checked, oldest_result.status,
                                     oldest_result.value,
                                     " pos %0d cnt %0d last %0d,", oldest_result.position,
                                     oldest_result.count, oldest_result.last,
                                     " got st %0d val %h pos %0d cnt %0d last %0d",
                                     status, value_res, position_res, count, last);
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 4);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        int directed_ops;
        int pick;
        int settle;
        gen_fill        = 0;
        ops_queued      = 0;
        list_fill       = 0;
        fail_count      = 0;
        results_checked = 0;
        listings_seen   = 0;
        full_rejects    = 0;

        // empty list corner cases and unused codes
        queue_op(ACT_LIST, 32'sh1234_5678, 0);
        queue_op(ACT_EDIT, rand_word(), 0);
        queue_op(ACT_DELETE, rand_word(), 31);
        queue_op(ACT_INSERT, rand_word(), 1);
        queue_op(ACT_SPARE_LO, rand_word(), $urandom_range(0, 31));
        queue_op(ACT_SPARE_HI, rand_word(), $urandom_range(0, 31));
        // word extremes, shifts at both ends and the middle
        queue_op(ACT_APPEND, 32'sh7fffffff, 31);
        queue_op(ACT_APPEND, 32'sh80000000, 0);
        queue_op(ACT_INSERT, -32'sd1, 0);
        queue_op(ACT_INSERT, 32'sd0, 3);
        queue_op(ACT_INSERT, 32'sh55555555, 2);
        queue_op(ACT_EDIT, 32'shaaaaaaaa, 1);
        queue_op(ACT_EDIT, rand_word(), 5);
        queue_op(ACT_DELETE, rand_word(), 0);
        queue_op(ACT_DELETE, rand_word(), 3);
        queue_op(ACT_DELETE, rand_word(), 3);
        queue_op(ACT_LIST, rand_word(), 17);
        queue_op(ACT_CLEAR, rand_word(), 9);
        queue_op(ACT_LIST, rand_word(), 0);
        queue_op(ACT_APPEND, 32'sd0, 0);
        queue_op(ACT_EDIT, -32'sd1, 0);
        queue_op(ACT_LIST, rand_word(), 0);
        directed_ops = ops_queued;

        // random part, opening with a run up to a full list
        queue_fill_burst();
        while (ops_queued < directed_ops + RANDOM_OPS)
        begin
            pick = $urandom_range(0, 24);
            if (pick == 0)
                queue_fill_burst();
            else if (pick < 19)
                queue_valid_op();
            else if (pick < 22)
                queue_broken_op();
            else
                queue_op(ACT_W'($urandom_range(0, 7)), rand_word(), $urandom_range(0, 31));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending_ops.size() == 0 && !in_valid && predicted_results.size() == 0) &&
               cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        settle = 0;
        while (settle < SETTLE_CYCLES && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            settle++;
        end

        if (cycle_count >= CYCLE_LIMIT)
            $display("TEST FAILED");
        else
        begin
            if (predicted_results.size() != 0)
            begin
                fail_count++;
                $display("%0d results never arrived", predicted_results.size());
            end
            $display("covered %0d operations, %0d results checked,",
                     items_accepted, results_checked,
                     " %0d listings, %0d full rejects", listings_seen, full_rejects);
            $display("long output hold-off of %0d cycles applied, %0d failures", HOLD_CYCLES,
                     fail_count);
            if (fail_count == 0)
                $display("TEST PASSED");
            else
                $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
src/isl_pkg.sv
src/isl_cell.sv
src/isl_out_fifo.sv
src/indexed_shift_list.sv
tb/tb.sv
